/* design/dpd_drv_pkg.sv */
// shared types and constants for the dual pd drive controller
// no dependencies; imported by dual_pd_drive_controller
`default_nettype none

package dpd_drv_pkg;

   // one request: a control step or a rezero, with both encoder positions
   typedef struct packed {
      logic              action;
      logic signed [31:0] left_position;
      logic signed [31:0] right_position;
   } req_type;

   // one result
   typedef struct packed {
      logic [14:0] left_power;
      logic [14:0] right_power;
      logic        goal_done;
      logic        still_running;
   } rsp_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_ANGLE_GAIN_P    = 3'd0;
   localparam csr_index_type CSR_ANGLE_GAIN_D    = 3'd1;
   localparam csr_index_type CSR_DIST_GAIN_P     = 3'd2;
   localparam csr_index_type CSR_DIST_GAIN_D     = 3'd3;
   localparam csr_index_type CSR_TARGET_DISTANCE = 3'd4;
   localparam csr_index_type CSR_TARGET_ANGLE    = 3'd5;
   localparam csr_index_type CSR_DONE_THRESHOLD  = 3'd6;

   // request action codes
   localparam logic ACTION_STEP   = 1'b0;
   localparam logic ACTION_REZERO = 1'b1;

   // register reset values
   localparam logic [31:0] ANGLE_GAIN_P_RESET    = 32'd393;
   localparam logic [31:0] ANGLE_GAIN_D_RESET    = 32'd655;
   localparam logic [31:0] DIST_GAIN_P_RESET     = 32'd655;
   localparam logic [31:0] DIST_GAIN_D_RESET     = 32'd0;
   localparam logic [15:0] TARGET_DISTANCE_RESET = 16'd0;
   localparam logic [15:0] TARGET_ANGLE_RESET    = 16'd0;
   localparam logic [15:0] DONE_THRESHOLD_RESET  = 16'd10;

   // power limits, q8.8 percent
   localparam logic [14:0] POWER_MAX_Q8 = 15'd20480;
   localparam logic [14:0] POWER_MIN_Q8 = 15'd2560;

endpackage

`default_nettype wire

/* design/dual_pd_drive_controller.sv */
// dual pd drive controller: top level, four-register pipeline
// depends on dpd_drv_pkg for payload types, register indexes and limits
`default_nettype none

// Dual PD drive controller for a differential robot. Each request is either
// a rezero, which captures both encoder positions as baselines, clears the
// two stored previous errors and clears the sticky goal flag, or a control
// step. A step forms the angle error (target_angle minus the difference of
// the travelled counts) and the distance error (target_distance minus their
// mean, truncated toward zero), both saturated to 32 bits, runs a PD
// correction on each with signed Q16 gains, and drives left = dist + angle,
// right = dist - angle, clamped to 10..80 percent in Q8.8. When the signed
// sum of the two errors is below done_threshold both powers are zero, the
// goal flag sets and still_running drops. Throughput is one request per
// clock while rsp_stall is low. Each request passes the request, product
// (four 32x32 multipliers), correction (two 65 bit adds) and result (66
// bit add and clamp) registers. The error feedback loop closes in the
// first stage, so back-to-back steps see the previous step's errors.
// The user must write registers through the csr port only while no
// request is in flight; the block does not enforce it. csr_ready is
// always high and writes to an index beyond the last register are dropped.
module dual_pd_drive_controller
   import dpd_drv_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,

   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,

   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data,

   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_wdata
);

   // q16 clamp limits on the 66 bit power sums
   localparam logic signed [65:0] POWER_MAX_Q16 = 66'sd5242880;
   localparam logic signed [65:0] POWER_MIN_Q16 = 66'sd655360;

   // saturate a 35 bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // clamp a q16 percent value into the q8.8 power range
   function automatic logic [14:0] clamp_power(input logic signed [65:0] q);
      logic [14:0] r;
      if (q > POWER_MAX_Q16) begin
         r = POWER_MAX_Q8;
      end else if (q < POWER_MIN_Q16) begin
         r = POWER_MIN_Q8;
      end else begin
         r = q[22:8];
      end
      return r;
   endfunction

   // configuration registers
   logic signed [31:0] angle_gain_p_ff, angle_gain_d_ff;
   logic signed [31:0] dist_gain_p_ff, dist_gain_d_ff;
   logic signed [15:0] target_distance_ff, target_angle_ff;
   logic [15:0]        done_threshold_ff;

   // controller state
   logic signed [31:0] base_left_ff, base_right_ff;
   logic signed [31:0] prev_angle_error_ff, prev_dist_error_ff;
   logic signed [31:0] prev_angle_error_in, prev_dist_error_in;
   logic               reached_ff, reached_in;

   // stage a: request register
   logic               a_valid_ff;
   req_type            a_req_ff;

   // stage b: products
   logic               b_valid_ff;
   logic               b_rezero_ff, b_done_ff;
   logic signed [63:0] b_ang_p_ff, b_ang_d_ff, b_dist_p_ff, b_dist_d_ff;
   logic signed [63:0] b_ang_p_in, b_ang_d_in, b_dist_p_in, b_dist_d_in;

   // stage c: corrections
   logic               c_valid_ff;
   logic               c_rezero_ff, c_done_ff;
   logic signed [64:0] c_ang_corr_ff, c_dist_corr_ff;
   logic signed [64:0] c_ang_corr_in, c_dist_corr_in;

   // result register
   logic               out_valid_ff;
   rsp_type            out_ff, out_in;

   // pipeline flow: a stage may load when it is empty or its content moves on
   logic out_free, c_free, b_free, a_free;
   logic a_move, b_move, c_move;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign c_free   = !c_valid_ff || out_free;
   assign b_free   = !b_valid_ff || c_free;
   assign a_free   = !a_valid_ff || b_free;
   assign a_move   = a_valid_ff && b_free;
   assign b_move   = b_valid_ff && c_free;
   assign c_move   = c_valid_ff && out_free;

   assign req_stall = !a_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign csr_ready = 1'b1;

   // register writes; unused index falls into the default arm
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_gain_p_ff    <= ANGLE_GAIN_P_RESET;
         angle_gain_d_ff    <= ANGLE_GAIN_D_RESET;
         dist_gain_p_ff     <= DIST_GAIN_P_RESET;
         dist_gain_d_ff     <= DIST_GAIN_D_RESET;
         target_distance_ff <= TARGET_DISTANCE_RESET;
         target_angle_ff    <= TARGET_ANGLE_RESET;
         done_threshold_ff  <= DONE_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ANGLE_GAIN_P:    angle_gain_p_ff    <= csr_wdata;
            CSR_ANGLE_GAIN_D:    angle_gain_d_ff    <= csr_wdata;
            CSR_DIST_GAIN_P:     dist_gain_p_ff     <= csr_wdata;
            CSR_DIST_GAIN_D:     dist_gain_d_ff     <= csr_wdata;
            CSR_TARGET_DISTANCE: target_distance_ff <= csr_wdata[15:0];
            CSR_TARGET_ANGLE:    target_angle_ff    <= csr_wdata[15:0];
            CSR_DONE_THRESHOLD:  done_threshold_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stage a: errors, deltas, products and goal test
   // ---------------------------------------------------------------
   logic signed [32:0] travel_left, travel_right;
   logic signed [33:0] travel_diff, travel_sum, travel_half;
   logic signed [31:0] angle_error, dist_error;
   logic signed [31:0] angle_delta, dist_delta;
   logic signed [33:0] error_sum;
   logic               a_done;

   always_comb begin
      travel_left  = 33'(a_req_ff.left_position) - 33'(base_left_ff);
      travel_right = 33'(a_req_ff.right_position) - 33'(base_right_ff);
      travel_diff  = 34'(travel_left) - 34'(travel_right);
      travel_sum   = 34'(travel_left) + 34'(travel_right);
      // mean truncated toward zero: bias odd negatives up before the shift
      travel_half  = $signed(travel_sum + {33'd0, travel_sum[33]}) >>> 1;

      angle_error = sat32(35'(target_angle_ff) - 35'(travel_diff));
      dist_error  = sat32(35'(target_distance_ff) - 35'(travel_half));
      angle_delta = sat32(35'(angle_error) - 35'(prev_angle_error_ff));
      dist_delta  = sat32(35'(dist_error) - 35'(prev_dist_error_ff));

      b_ang_p_in  = angle_gain_p_ff * angle_error;
      b_ang_d_in  = angle_gain_d_ff * angle_delta;
      b_dist_p_in = dist_gain_p_ff * dist_error;
      b_dist_d_in = dist_gain_d_ff * dist_delta;

      error_sum = 34'(angle_error) + 34'(dist_error);
      a_done    = error_sum < $signed({18'd0, done_threshold_ff});

      // rezero clears the error history, a step records its errors
      if (a_req_ff.action == ACTION_REZERO) begin
         prev_angle_error_in = '0;
         prev_dist_error_in  = '0;
      end else begin
         prev_angle_error_in = angle_error;
         prev_dist_error_in  = dist_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff          <= 1'b0;
         base_left_ff        <= '0;
         base_right_ff       <= '0;
         prev_angle_error_ff <= '0;
         prev_dist_error_ff  <= '0;
      end else begin
         if (a_free) begin
            a_valid_ff <= req_valid;
         end
         // state follows each request as it leaves the request register
         if (a_move) begin
            prev_angle_error_ff <= prev_angle_error_in;
            prev_dist_error_ff  <= prev_dist_error_in;
            if (a_req_ff.action == ACTION_REZERO) begin
               base_left_ff  <= a_req_ff.left_position;
               base_right_ff <= a_req_ff.right_position;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_free) begin
         a_req_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------
   // stage b: pd sums, exact in 65 bits
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_free) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_free) begin
         b_rezero_ff <= (a_req_ff.action == ACTION_REZERO);
         b_done_ff   <= a_done;
         b_ang_p_ff  <= b_ang_p_in;
         b_ang_d_ff  <= b_ang_d_in;
         b_dist_p_ff <= b_dist_p_in;
         b_dist_d_ff <= b_dist_d_in;
      end
   end

   // exact sums clamp to the same powers as the 64 bit saturating ones
   assign c_ang_corr_in  = 65'(b_ang_p_ff) + 65'(b_ang_d_ff);
   assign c_dist_corr_in = 65'(b_dist_p_ff) + 65'(b_dist_d_ff);

   // ---------------------------------------------------------------
   // stage c: wheel mix, clamp, goal and rezero override
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_free) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_free) begin
         c_rezero_ff    <= b_rezero_ff;
         c_done_ff      <= b_done_ff;
         c_ang_corr_ff  <= c_ang_corr_in;
         c_dist_corr_ff <= c_dist_corr_in;
      end
   end

   logic signed [65:0] left_q16, right_q16;

   always_comb begin
      left_q16  = 66'(c_dist_corr_ff) + 66'(c_ang_corr_ff);
      right_q16 = 66'(c_dist_corr_ff) - 66'(c_ang_corr_ff);
      reached_in = reached_ff;
      out_in.left_power    = clamp_power(left_q16);
      out_in.right_power   = clamp_power(right_q16);
      out_in.goal_done     = reached_ff;
      out_in.still_running = 1'b1;
      if (c_rezero_ff) begin
         reached_in    = 1'b0;
         out_in        = '0;
      end else if (c_done_ff) begin
         reached_in = 1'b1;
         out_in.left_power    = '0;
         out_in.right_power   = '0;
         out_in.goal_done     = 1'b1;
         out_in.still_running = 1'b0;
      end
   end

   // sticky goal flag updates in request order as results are formed
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         reached_ff   <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= c_valid_ff;
         end
         if (c_move) begin
            reached_ff <= reached_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_move) begin
         out_ff <= out_in;
      end
   end

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------

   // a running step always drives both wheels inside the clamp range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.still_running |->
         rsp_data.left_power >= POWER_MIN_Q8 && rsp_data.left_power <= POWER_MAX_Q8 &&
         rsp_data.right_power >= POWER_MIN_Q8 && rsp_data.right_power <= POWER_MAX_Q8)
      else $error("running result with power outside clamp range");

   // a stopped result (goal or rezero) never drives the wheels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.still_running |->
         rsp_data.left_power == '0 && rsp_data.right_power == '0)
      else $error("stopped result with nonzero power");

   // stall only when the request register holds a request that cannot move
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff && b_valid_ff && c_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled while pipeline has room");

   // a rezero leaving the request register clears the error history
   assert property (@(posedge clock) disable iff (reset)
      a_move && a_req_ff.action == ACTION_REZERO |=>
         prev_angle_error_ff == '0 && prev_dist_error_ff == '0)
      else $error("rezero did not clear previous errors");

   // a goal result always reports the sticky flag set
   assert property (@(posedge clock) disable iff (reset)
      c_move && c_done_ff && !c_rezero_ff |=> reached_ff && out_ff.goal_done)
      else $error("goal reached without setting the goal flag");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench for dual_pd_drive_controller: directed and random requests checked
// against an in-bench model of the two pd loops; needs dpd_drv_pkg and the rtl

module testbench
   import dpd_drv_pkg::*;
();

   // the last index of the three-bit field has no register behind it
   localparam csr_index_type CSR_INDEX_UNUSED = 3'd7;

   localparam int PIPE_LATENCY     = 3;
   localparam int REQUESTS_PER_RUN = 250;
   localparam int RANDOM_PHASES    = 6;

   localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] POS_MIN  = 32'h8000_0000;
   localparam longint      S32_MAX  = 64'sd2147483647;
   localparam longint      S32_MIN  = -64'sd2147483648;
   localparam longint      S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint      S64_MIN  = 64'sh8000_0000_0000_0000;
   localparam longint      Q16_HIGH = 64'sd5242880;   // 80 percent
   localparam longint      Q16_LOW  = 64'sd655360;    // 10 percent

   // register settings used by the random phases
   typedef enum {PROFILE_TYPICAL, PROFILE_FLOOR, PROFILE_WILD} profile_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   logic [31:0]   csr_wdata = '0;

   dual_pd_drive_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // local copy of the register file, updated when a csr write lands
   logic signed [31:0] gain_angle_p  = ANGLE_GAIN_P_RESET;
   logic signed [31:0] gain_angle_d  = ANGLE_GAIN_D_RESET;
   logic signed [31:0] gain_dist_p   = DIST_GAIN_P_RESET;
   logic signed [31:0] gain_dist_d   = DIST_GAIN_D_RESET;
   logic signed [15:0] goal_distance = TARGET_DISTANCE_RESET;
   logic signed [15:0] goal_angle    = TARGET_ANGLE_RESET;
   logic        [15:0] done_limit    = DONE_THRESHOLD_RESET;

   // controller state as seen from outside
   logic signed [31:0] base_left_pos  = '0;
   logic signed [31:0] base_right_pos = '0;
   logic signed [31:0] last_angle_err = '0;
   logic signed [31:0] last_dist_err  = '0;
   logic               goal_latched   = 1'b0;

   req_type pending_requests[$];
   rsp_type expected_powers[$];
   rsp_type head_result;

   int  queued_count   = 0;
   int  sender_gap     = 0;
   int  receiver_gap   = 0;
   int  mismatch_count = 0;
   bit  quiet_tail     = 1'b0;

   // coverage tallies for the closing summary
   int  step_count     = 0;
   int  rezero_count   = 0;
   int  goal_hits      = 0;
   int  top_clamps     = 0;
   int  floor_clamps   = 0;

   // ---------------------------------------------------------------------
   // drive model
   // ---------------------------------------------------------------------

   // errors and error changes are held to the signed 32 bit range
   function automatic longint clip32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // 64 bit add that sticks at the rails instead of wrapping
   function automatic longint add_sat64(input longint a, input longint b);
      logic signed [64:0] wa, wb, s;
      wa = a;
      wb = b;
      s  = wa + wb;
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   function automatic longint neg_sat64(input longint a);
      return (a == S64_MIN) ? S64_MAX : -a;
   endfunction

   // proportional term plus derivative term, both q16 percent
   function automatic longint pd_term(input logic signed [31:0] kp,
                                      input logic signed [31:0] kd,
                                      input longint err, input longint prev);
      longint delta, p_part, d_part;
      delta  = clip32(err - prev);
      p_part = longint'(kp) * err;
      d_part = longint'(kd) * delta;
      return add_sat64(p_part, d_part);
   endfunction

   // q16 correction to q8.8 power, held to the 10..80 percent band
   function automatic logic [14:0] to_power(input longint q16);
      longint shifted;
      if (q16 > Q16_HIGH) begin
         top_clamps++;
         return POWER_MAX_Q8;
      end
      if (q16 < Q16_LOW) begin
         floor_clamps++;
         return POWER_MIN_Q8;
      end
      shifted = q16 >>> 8;
      return shifted[14:0];
   endfunction

   // next result of the controller for one accepted request
   function automatic rsp_type predict_drive(input req_type r);
      rsp_type res;
      longint  trav_l, trav_r, ang_err, dist_err, ang_corr, dist_corr, limit;
      res = '0;
      if (r.action == ACTION_REZERO) begin
         // new baselines, derivative history and goal flag cleared
         base_left_pos  = r.left_position;
         base_right_pos = r.right_position;
         last_angle_err = '0;
         last_dist_err  = '0;
         goal_latched   = 1'b0;
         rezero_count++;
         return res;
      end
      step_count++;
      trav_l    = longint'(r.left_position) - longint'(base_left_pos);
      trav_r    = longint'(r.right_position) - longint'(base_right_pos);
      // mean travel truncates toward zero, same as longint division
      ang_err   = clip32(longint'(goal_angle) - (trav_l - trav_r));
      dist_err  = clip32(longint'(goal_distance) - (trav_l + trav_r) / 2);
      ang_corr  = pd_term(gain_angle_p, gain_angle_d, ang_err, longint'(last_angle_err));
      dist_corr = pd_term(gain_dist_p, gain_dist_d, dist_err, longint'(last_dist_err));
      last_angle_err = ang_err[31:0];
      last_dist_err  = dist_err[31:0];
      res.left_power    = to_power(add_sat64(dist_corr, ang_corr));
      res.right_power   = to_power(add_sat64(dist_corr, neg_sat64(ang_corr)));
      res.still_running = 1'b1;
      limit = done_limit;
      // goal test on the exact error sum; history is updated either way
      if (ang_err + dist_err < limit) begin
         res.left_power    = '0;
         res.right_power   = '0;
         res.still_running = 1'b0;
         goal_latched      = 1'b1;
         goal_hits++;
      end
      res.goal_done = goal_latched;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // request driver: pops pending requests, random idle bursts
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // the edge that takes a request is where its result is predicted
         if (req_valid && !req_stall)
            expected_powers.push_back(predict_drive(req_data));

         if (req_valid && req_stall) begin
            // stalled request is held unchanged
         end else if (sender_gap > 0) begin
            sender_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            sender_gap = $urandom_range(1, 7) - 1;
            req_valid <= 1'b0;
         end else begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // result monitor: random stall bursts, in-order compare
   // ---------------------------------------------------------------------
   task automatic count_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               count_failure($sformatf("unexpected result at %0t: L=%0d R=%0d done=%b run=%b",
                  $time, rsp_data.left_power, rsp_data.right_power,
                  rsp_data.goal_done, rsp_data.still_running));
            end else begin
               head_result = expected_powers.pop_front();
               if (rsp_data.left_power !== head_result.left_power ||
                   rsp_data.right_power !== head_result.right_power ||
                   rsp_data.goal_done !== head_result.goal_done ||
                   rsp_data.still_running !== head_result.still_running)
                  count_failure($sformatf(
                     {"mismatch at %0t: expected L=%0d R=%0d done=%b run=%b,",
                      " got L=%0d R=%0d done=%b run=%b"},
                     $time, head_result.left_power, head_result.right_power,
                     head_result.goal_done, head_result.still_running,
                     rsp_data.left_power, rsp_data.right_power,
                     rsp_data.goal_done, rsp_data.still_running));
            end
         end

         if (receiver_gap > 0) begin
            receiver_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            receiver_gap = $urandom_range(1, 7) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void queue_request(input logic action, input logic [31:0] left,
                                         input logic [31:0] right);
      req_type r;
      r.action         = action;
      r.left_position  = left;
      r.right_position = right;
      pending_requests.push_back(r);
      queued_count++;
   endfunction

   // csr write; the local register copy follows the accepted write
   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ANGLE_GAIN_P:    gain_angle_p  = value;
         CSR_ANGLE_GAIN_D:    gain_angle_d  = value;
         CSR_DIST_GAIN_P:     gain_dist_p   = value;
         CSR_DIST_GAIN_D:     gain_dist_d   = value;
         CSR_TARGET_DISTANCE: goal_distance = value[15:0];
         CSR_TARGET_ANGLE:    goal_angle    = value[15:0];
         CSR_DONE_THRESHOLD:  done_limit    = value[15:0];
         default: ;   // no register here, write dropped
      endcase
   endtask

   task automatic write_all_gains(input logic [31:0] value);
      write_register(CSR_ANGLE_GAIN_P, value);
      write_register(CSR_ANGLE_GAIN_D, value);
      write_register(CSR_DIST_GAIN_P, value);
      write_register(CSR_DIST_GAIN_D, value);
   endtask

   // wait until every request is sent and every result is back, then let the pipe settle
   task automatic wait_idle();
      while (pending_requests.size() != 0 || expected_powers.size() != 0 || req_valid)
         @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // full register set for one random phase; 16 bit registers get junk upper bits
   task automatic load_profile(input profile_type kind);
      logic [31:0] gain;
      for (int k = CSR_ANGLE_GAIN_P; k <= CSR_DIST_GAIN_D; k++) begin
         if (kind == PROFILE_WILD && $urandom_range(0, 1) == 1)
            gain = $urandom();
         else
            gain = $urandom_range(0, 3000) - 500;
         write_register(csr_index_type'(k), gain);
      end
      case (kind)
         PROFILE_FLOOR: begin
            write_register(CSR_TARGET_DISTANCE, {16'($urandom()), 16'h8000});
            write_register(CSR_TARGET_ANGLE, {16'($urandom()), 16'h8000});
            write_register(CSR_DONE_THRESHOLD, {16'($urandom()), 16'h0000});
         end
         PROFILE_WILD: begin
            write_register(CSR_TARGET_DISTANCE, {16'($urandom()), 16'h7FFF});
            write_register(CSR_TARGET_ANGLE, $urandom());
            write_register(CSR_DONE_THRESHOLD, {16'($urandom()), 16'hFFFF});
         end
         default: begin
            write_register(CSR_TARGET_DISTANCE,
                           {16'($urandom()), 16'($urandom_range(200, 8000))});
            write_register(CSR_TARGET_ANGLE,
                           {16'($urandom()), 16'($urandom_range(0, 400) - 200)});
            write_register(CSR_DONE_THRESHOLD,
                           {16'($urandom()), 16'($urandom_range(0, 200))});
         end
      endcase
   endtask

   // one drive: rezero, then a walk of steps toward the goal with the odd
   // stray step or surprise rezero mixed in
   function automatic void queue_drive_run();
      logic [31:0] base_l, base_r, moved_l, moved_r;
      int          run_len;
      base_l  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000000) - 1000000;
      base_r  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000000) - 1000000;
      run_len = $urandom_range(4, 40);
      moved_l = '0;
      moved_r = '0;
      queue_request(ACTION_REZERO, base_l, base_r);
      for (int n = 0; n < run_len; n++) begin
         moved_l += $urandom_range(0, 500) - 100;
         moved_r += $urandom_range(0, 500) - 100;
         case ($urandom_range(0, 19))
            0:       queue_request(ACTION_STEP, $urandom(), $urandom());
            1:       queue_request(ACTION_REZERO, $urandom(), $urandom());
            default: queue_request(ACTION_STEP, base_l + moved_l, base_r + moved_r);
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset registers: goal met at once and sticky, then wide travel
      // from the position extremes (error saturation, both clamps)
      queue_request(ACTION_STEP, 32'd0, 32'd0);
      queue_request(ACTION_STEP, 32'd100, 32'd40);
      queue_request(ACTION_REZERO, POS_MIN, POS_MAX);
      queue_request(ACTION_STEP, POS_MIN, POS_MIN);
      queue_request(ACTION_REZERO, POS_MAX, POS_MIN);
      queue_request(ACTION_STEP, POS_MIN, POS_MAX);
      queue_request(ACTION_REZERO, 32'd0, 32'd0);
      wait_idle();

      // a plain forward drive: mid-band powers, goal, flag stays set,
      // then a rezero clears it
      write_register(CSR_TARGET_DISTANCE, 32'd5000);
      queue_request(ACTION_STEP, 32'd0, 32'd0);
      queue_request(ACTION_STEP, 32'd1000, 32'd900);
      queue_request(ACTION_STEP, 32'd4000, 32'd4100);
      queue_request(ACTION_STEP, 32'd5000, 32'd5000);
      queue_request(ACTION_STEP, 32'd4000, 32'd4000);
      queue_request(ACTION_REZERO, 32'd7, -32'sd7);
      queue_request(ACTION_STEP, 32'd7, -32'sd7);
      wait_idle();

      // largest positive gains: both error terms near the top, the power
      // sum saturates at the 64 bit rail
      write_all_gains(POS_MAX);
      write_register(CSR_TARGET_DISTANCE, 32'h0000_7FFF);
      write_register(CSR_TARGET_ANGLE, 32'h0000_7FFF);
      write_register(CSR_DONE_THRESHOLD, 32'h0000_FFFF);
      queue_request(ACTION_REZERO, POS_MAX, 32'd0);
      queue_request(ACTION_STEP, POS_MIN, POS_MIN);
      queue_request(ACTION_STEP, POS_MIN, POS_MIN);
      wait_idle();

      // most negative gains: same travel, sum saturates at the bottom rail
      write_all_gains(POS_MIN);
      queue_request(ACTION_REZERO, POS_MAX, 32'd0);
      queue_request(ACTION_STEP, POS_MIN, POS_MIN);
      wait_idle();

      // index past the register file must change nothing
      write_register(CSR_INDEX_UNUSED, $urandom());

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         int phase_goal;
         case (phase)
            1:       load_profile(PROFILE_FLOOR);
            2:       load_profile(PROFILE_WILD);
            default: load_profile(PROFILE_TYPICAL);
         endcase
         // last phase runs back to back with no idling on either side
         if (phase == RANDOM_PHASES - 1) quiet_tail = 1'b1;
         phase_goal = queued_count + REQUESTS_PER_RUN;
         while (queued_count < phase_goal) queue_drive_run();
         wait_idle();
      end

      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (expected_powers.size() != 0)
         count_failure($sformatf("%0d results never arrived", expected_powers.size()));

      $display("covered %0d steps and %0d rezeros, goal reached on %0d steps",
               step_count, rezero_count, goal_hits);
      $display("power clamped high %0d times and low %0d times, %0d mismatches",
               top_clamps, floor_clamps, mismatch_count);
      if (mismatch_count == 0)
         $display("[dual_pd_drive_controller] OK");
      else
         $display("[dual_pd_drive_controller] ERROR");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("timeout with %0d results outstanding", expected_powers.size());
      $display("[dual_pd_drive_controller] ERROR");
      $finish;
   end

endmodule
